### hw/rtl/shtn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shtn_pkg;

    // Store sizes and field widths.
    localparam int HIST_BINS   = 12;
    localparam int TOP_ENTRIES = 12;
    localparam int DUMP_LEN    = (HIST_BINS > TOP_ENTRIES) ? HIST_BINS : TOP_ENTRIES;
    localparam int SMALL_LIMIT = 16;

    localparam int SIZE_W  = 32;
    localparam int ADDR_W  = 32;
    localparam int CNT_W   = 32;
    localparam int BYTES_W = 48;
    localparam int IDX_W   = 4;

    localparam int DUMP_W = $clog2(DUMP_LEN);
    localparam int BIN_W  = $clog2(HIST_BINS);
    localparam int TOP_IW = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1;

    // Operation codes.
    typedef logic [1:0] op_t;
    localparam op_t OP_RECORD = 2'd0;
    localparam op_t OP_DUMP   = 2'd1;
    localparam op_t OP_CLEAR  = 2'd2;

    typedef struct packed {
        op_t                operation;
        logic [SIZE_W-1:0]  block_size;
        logic               block_used;
        logic [ADDR_W-1:0]  block_address;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]   entry_index;
        logic [CNT_W-1:0]   bin_count;
        logic [BYTES_W-1:0] bin_bytes;
        logic [SIZE_W-1:0]  top_size;
        logic [ADDR_W-1:0]  top_address;
        logic [CNT_W-1:0]   total_blocks;
        logic [BYTES_W-1:0] total_bytes;
        logic               last_entry;
    } rsp_t;

    // Control from the top level to the top list.
    typedef struct packed {
        logic insert;
        logic clear;
    } tl_ctl_t;

    // Power-of-two bin of a block size; the thresholds rise, so the last hit wins.
    function automatic logic [BIN_W-1:0] bin_of(input logic [SIZE_W-1:0] size);
        logic [BIN_W-1:0] b;
        b = '0;
        for (int i = 1; i < HIST_BINS; i++) begin
            if (size >= (SIZE_W'(SMALL_LIMIT) << (i - 1))) begin
                b = BIN_W'(i);
            end
        end
        return b;
    endfunction

    // Count increment that sticks at all ones.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
        return (&cnt) ? cnt : cnt + CNT_W'(1);
    endfunction

    // Byte sum add that sticks at all ones.
    function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] sum,
                                                   input logic [SIZE_W-1:0]  size);
        logic [BYTES_W:0] s;
        s = {1'b0, sum} + (BYTES_W + 1)'(size);
        return s[BYTES_W] ? {BYTES_W{1'b1}} : s[BYTES_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/shtn_top_list.sv
`timescale 1ns / 1ps
`default_nettype none

module shtn_top_list (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire shtn_pkg::tl_ctl_t              ctl,
    input  wire logic [shtn_pkg::SIZE_W-1:0]    size,
    input  wire logic [shtn_pkg::ADDR_W-1:0]    addr,
    input  wire logic [shtn_pkg::DUMP_W-1:0]    rank,
    output logic      [shtn_pkg::SIZE_W-1:0]    rank_size,
    output logic      [shtn_pkg::ADDR_W-1:0]    rank_addr
);

    logic [shtn_pkg::SIZE_W-1:0] size_reg  [shtn_pkg::TOP_ENTRIES];
    logic [shtn_pkg::ADDR_W-1:0] addr_reg  [shtn_pkg::TOP_ENTRIES];
    logic [shtn_pkg::SIZE_W-1:0] size_next [shtn_pkg::TOP_ENTRIES];
    logic [shtn_pkg::ADDR_W-1:0] addr_next [shtn_pkg::TOP_ENTRIES];
    logic [shtn_pkg::TOP_ENTRIES-1:0] gt;

    // The list is descending, so the strict compares form a thermometer code.
    // The first rank that compares larger takes the new block and the ranks
    // below it take their upper neighbor.
    always_comb
    begin
        for (int i = 0; i < shtn_pkg::TOP_ENTRIES; i++) begin
            gt[i] = size > size_reg[i];
        end
        for (int i = 0; i < shtn_pkg::TOP_ENTRIES; i++) begin
            size_next[i] = size_reg[i];
            addr_next[i] = addr_reg[i];
            if (gt[i]) begin
                if (i == 0) begin
                    size_next[i] = size;
                    addr_next[i] = addr;
                end else if (!gt[i - 1]) begin
                    size_next[i] = size;
                    addr_next[i] = addr;
                end else begin
                    size_next[i] = size_reg[i - 1];
                    addr_next[i] = addr_reg[i - 1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < shtn_pkg::TOP_ENTRIES; i++) begin
                size_reg[i] <= '0;
                addr_reg[i] <= '0;
            end
        end else if (ctl.clear) begin
            for (int i = 0; i < shtn_pkg::TOP_ENTRIES; i++) begin
                size_reg[i] <= '0;
                addr_reg[i] <= '0;
            end
        end else if (ctl.insert) begin
            for (int i = 0; i < shtn_pkg::TOP_ENTRIES; i++) begin
                size_reg[i] <= size_next[i];
                addr_reg[i] <= addr_next[i];
            end
        end
    end

    // Read port for the dump; ranks past the list read as zero.
    always_comb
    begin
        rank_size = '0;
        rank_addr = '0;
        if (int'(rank) < shtn_pkg::TOP_ENTRIES) begin
            rank_size = size_reg[rank[shtn_pkg::TOP_IW-1:0]];
            rank_addr = addr_reg[rank[shtn_pkg::TOP_IW-1:0]];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/size_histogram_top_n_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Heap block size histogram with a list of the largest blocks. A record of a
// used block updates its bin and the top list (parallel compares and a shift)
// while it sits in the input register, and a record of an unused block changes
// nothing; a record can be accepted on every clock while no dump is held, and
// clears likewise never wait. A dump holds the input register while it emits
// DUMP_LEN result transactions, one per cycle through the output register
// while the result side does not stall; later transactions wait behind it and
// see the state as the dump left it.
module size_histogram_top_n_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire shtn_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output shtn_pkg::rsp_t      rsp
);

    // Input register.
    shtn_pkg::req_t req_reg;
    logic           req_vld_reg;

    // Histogram and totals.
    logic [shtn_pkg::CNT_W-1:0]   bin_cnt_reg    [shtn_pkg::HIST_BINS];
    logic [shtn_pkg::BYTES_W-1:0] bin_bytes_reg  [shtn_pkg::HIST_BINS];
    logic [shtn_pkg::CNT_W-1:0]   bin_cnt_next   [shtn_pkg::HIST_BINS];
    logic [shtn_pkg::BYTES_W-1:0] bin_bytes_next [shtn_pkg::HIST_BINS];
    logic [shtn_pkg::CNT_W-1:0]   blk_total_reg;
    logic [shtn_pkg::BYTES_W-1:0] byte_total_reg;

    // Dump sequencing and output register.
    logic [shtn_pkg::DUMP_W-1:0]  dump_cnt_reg;
    shtn_pkg::rsp_t               rsp_reg;
    shtn_pkg::rsp_t               rsp_next;
    logic                         rsp_vld_reg;

    logic                         is_record;
    logic                         is_clear;
    logic                         is_dump;
    logic                         rsp_load;
    logic                         dump_last;
    logic                         consume;
    logic [shtn_pkg::BIN_W-1:0]   bin_sel;
    shtn_pkg::tl_ctl_t            tl_ctl;
    logic [shtn_pkg::SIZE_W-1:0]  rank_size;
    logic [shtn_pkg::ADDR_W-1:0]  rank_addr;

    // Decode of the held transaction.
    assign is_record = req_vld_reg && (req_reg.operation == shtn_pkg::OP_RECORD)
                       && req_reg.block_used;
    assign is_clear  = req_vld_reg && (req_reg.operation == shtn_pkg::OP_CLEAR);
    assign is_dump   = req_vld_reg && (req_reg.operation == shtn_pkg::OP_DUMP);
    assign rsp_load  = is_dump && (!rsp_vld_reg || !rsp_stall);
    assign dump_last = int'(dump_cnt_reg) == shtn_pkg::DUMP_LEN - 1;
    assign consume   = is_dump ? (rsp_load && dump_last) : 1'b1;
    assign req_stall = req_vld_reg && !consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_vld_reg <= 1'b0;
        end else if (!req_stall) begin
            req_vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall) begin
            req_reg <= req;
        end
    end

    // Each bin has its own saturating update; only the selected one is written.
    assign bin_sel = shtn_pkg::bin_of(req_reg.block_size);

    always_comb
    begin
        for (int i = 0; i < shtn_pkg::HIST_BINS; i++) begin
            bin_cnt_next[i]   = bin_cnt_reg[i];
            bin_bytes_next[i] = bin_bytes_reg[i];
            if (int'(bin_sel) == i) begin
                bin_cnt_next[i]   = shtn_pkg::sat_inc(bin_cnt_reg[i]);
                bin_bytes_next[i] = shtn_pkg::sat_add(bin_bytes_reg[i], req_reg.block_size);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < shtn_pkg::HIST_BINS; i++) begin
                bin_cnt_reg[i]   <= '0;
                bin_bytes_reg[i] <= '0;
            end
            blk_total_reg  <= '0;
            byte_total_reg <= '0;
        end else if (is_clear) begin
            for (int i = 0; i < shtn_pkg::HIST_BINS; i++) begin
                bin_cnt_reg[i]   <= '0;
                bin_bytes_reg[i] <= '0;
            end
            blk_total_reg  <= '0;
            byte_total_reg <= '0;
        end else if (is_record) begin
            for (int i = 0; i < shtn_pkg::HIST_BINS; i++) begin
                bin_cnt_reg[i]   <= bin_cnt_next[i];
                bin_bytes_reg[i] <= bin_bytes_next[i];
            end
            blk_total_reg  <= shtn_pkg::sat_inc(blk_total_reg);
            byte_total_reg <= shtn_pkg::sat_add(byte_total_reg, req_reg.block_size);
        end
    end

    // Top list of the largest blocks.
    assign tl_ctl.insert = is_record;
    assign tl_ctl.clear  = is_clear;

    shtn_top_list u_top_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (tl_ctl),
        .size      (req_reg.block_size),
        .addr      (req_reg.block_address),
        .rank      (dump_cnt_reg),
        .rank_size (rank_size),
        .rank_addr (rank_addr)
    );

    // Dump entry assembly; bins past the histogram read as zero.
    always_comb
    begin
        rsp_next              = '0;
        rsp_next.entry_index  = shtn_pkg::IDX_W'(dump_cnt_reg);
        if (int'(dump_cnt_reg) < shtn_pkg::HIST_BINS) begin
            rsp_next.bin_count = bin_cnt_reg[dump_cnt_reg[shtn_pkg::BIN_W-1:0]];
            rsp_next.bin_bytes = bin_bytes_reg[dump_cnt_reg[shtn_pkg::BIN_W-1:0]];
        end
        rsp_next.top_size     = rank_size;
        rsp_next.top_address  = rank_addr;
        rsp_next.total_blocks = blk_total_reg;
        rsp_next.total_bytes  = byte_total_reg;
        rsp_next.last_entry   = dump_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dump_cnt_reg <= '0;
            rsp_vld_reg  <= 1'b0;
        end else begin
            if (rsp_load) begin
                dump_cnt_reg <= dump_last ? '0 : dump_cnt_reg + shtn_pkg::DUMP_W'(1);
                rsp_vld_reg  <= 1'b1;
            end else if (!rsp_stall) begin
                rsp_vld_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load) begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    // A dump in progress keeps its transaction in the input register.
    a_dump_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (dump_cnt_reg != '0) |-> is_dump)
        else $error("dump counter active without a held dump transaction");

    // The final entry of a dump carries the last index.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.last_entry) |->
            (rsp.entry_index == shtn_pkg::IDX_W'(shtn_pkg::DUMP_LEN - 1)))
        else $error("last entry flag on a wrong index");

    // A new result only appears after a dump was being served.
    a_rsp_from_dump: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(is_dump))
        else $error("result without a dump transaction");

    // Records and clears never wait in the input register.
    a_no_stall_record: assert property (@(posedge clk) disable iff (!rst_n)
        (req_vld_reg && (req_reg.operation != shtn_pkg::OP_DUMP)) |-> !req_stall)
        else $error("non-dump transaction stalled");

endmodule

`default_nettype wire
